// ===== design/msd_pkg.sv =====
package msd_pkg;

   localparam int CFG_BITS   = 7;
   localparam int LAG_BITS   = 6;
   localparam int SUM_BITS   = 64;
   localparam int COUNT_BITS = 24;
   localparam int MSD_BITS   = 63;

   typedef struct packed {
      logic accept;
      logic present;
      logic unload;
      logic clear;
   } mds_ctl_type;

endpackage

// ===== design/msd_cell.sv =====
module msd_cell #(
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  msd_pkg::mds_ctl_type                  ctl,
   input  logic signed [COORD_BITS-1:0]          new_x,
   input  logic signed [COORD_BITS-1:0]          new_y,
   input  logic signed [COORD_BITS-1:0]          new_z,
   input  logic signed [COORD_BITS-1:0]          tap_x_in,
   input  logic signed [COORD_BITS-1:0]          tap_y_in,
   input  logic signed [COORD_BITS-1:0]          tap_z_in,
   input  logic                                  tap_valid_in,
   output logic signed [COORD_BITS-1:0]          tap_x_out,
   output logic signed [COORD_BITS-1:0]          tap_y_out,
   output logic signed [COORD_BITS-1:0]          tap_z_out,
   output logic                                  tap_valid_out,
   input  logic [msd_pkg::SUM_BITS-1:0]          sum_in,
   input  logic [msd_pkg::COUNT_BITS-1:0]        count_in,
   output logic [msd_pkg::SUM_BITS-1:0]          sum_out,
   output logic [msd_pkg::COUNT_BITS-1:0]        count_out
);
   import msd_pkg::*;

   localparam int SQ_BITS = 2 * COORD_BITS;
   localparam int D2_BITS = SQ_BITS + 2;

   logic signed [COORD_BITS-1:0] tx_ff, ty_ff, tz_ff;
   logic                         tv_ff;
   logic [COORD_BITS-1:0]        ax_ff, ay_ff, az_ff;
   logic                         s1_ff, s2_ff, s3_ff;
   logic [SQ_BITS-1:0]           qx_ff, qy_ff, qz_ff;
   logic [D2_BITS-1:0]           d2_ff;
   logic [SUM_BITS-1:0]          sum_ff;
   logic [COUNT_BITS-1:0]        cnt_ff;

   logic signed [COORD_BITS:0]   dx, dy, dz;
   logic [COORD_BITS:0]          mx, my, mz;
   logic [SUM_BITS:0]            add_w;
   logic                         pair_ok;

   assign pair_ok = ctl.accept & ctl.present & tap_valid_in;

   always_comb begin
      dx = {new_x[COORD_BITS-1], new_x} - {tap_x_in[COORD_BITS-1], tap_x_in};
      dy = {new_y[COORD_BITS-1], new_y} - {tap_y_in[COORD_BITS-1], tap_y_in};
      dz = {new_z[COORD_BITS-1], new_z} - {tap_z_in[COORD_BITS-1], tap_z_in};
      mx = dx[COORD_BITS] ? -dx : dx;
      my = dy[COORD_BITS] ? -dy : dy;
      mz = dz[COORD_BITS] ? -dz : dz;
      add_w = {1'b0, sum_ff} + {{(SUM_BITS + 1 - D2_BITS){1'b0}}, d2_ff};
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         tx_ff <= tap_x_in;
         ty_ff <= tap_y_in;
         tz_ff <= tap_z_in;
      end
      ax_ff <= mx[COORD_BITS-1:0];
      ay_ff <= my[COORD_BITS-1:0];
      az_ff <= mz[COORD_BITS-1:0];
      qx_ff <= SQ_BITS'(ax_ff) * SQ_BITS'(ax_ff);
      qy_ff <= SQ_BITS'(ay_ff) * SQ_BITS'(ay_ff);
      qz_ff <= SQ_BITS'(az_ff) * SQ_BITS'(az_ff);
      d2_ff <= D2_BITS'(qx_ff) + D2_BITS'(qy_ff) + D2_BITS'(qz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff  <= 1'b0;
         s1_ff  <= 1'b0;
         s2_ff  <= 1'b0;
         s3_ff  <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (ctl.accept) tv_ff <= tap_valid_in;
         s1_ff <= pair_ok;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         if (ctl.clear) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end else if (ctl.unload) begin
            sum_ff <= sum_in;
            cnt_ff <= count_in;
         end else if (s3_ff) begin
            sum_ff <= add_w[SUM_BITS] ? '1 : add_w[SUM_BITS-1:0];
            if (cnt_ff != '1) cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign tap_x_out     = tx_ff;
   assign tap_y_out     = ty_ff;
   assign tap_z_out     = tz_ff;
   assign tap_valid_out = tv_ff;
   assign sum_out       = sum_ff;
   assign count_out     = cnt_ff;

endmodule

// ===== design/mean_square_displacement_top.sv =====
// Mean squared displacement per time lag. Frames stream in one per cycle: a row
// of per-lag cells holds the current particle's past frames and compares each
// new frame against all of them at once, accumulating squared displacement and
// pair count per lag through a four-stage cell pipeline. When the last frame of
// the final particle is taken, input stalls: the cells drain in ST_DRAIN, then
// each lag is shifted out of the row and divided by a shared bit-serial divider,
// each result held until the receiver takes it. After the last result the
// accumulators clear and input resumes.
module mean_square_displacement_top #(
   parameter int MAX_FRAMES = 64,
   parameter int COORD_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msd_pkg::CFG_BITS-1:0]         csr_frames_in_use,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_present,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic signed [COORD_BITS-1:0]         req_pos_z,
   input  logic                                 req_final_particle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [msd_pkg::LAG_BITS-1:0]         rsp_lag,
   output logic [msd_pkg::MSD_BITS-1:0]         rsp_msd_value,
   output logic [msd_pkg::COUNT_BITS-1:0]       rsp_pair_count,
   output logic                                 rsp_no_pairs,
   output logic                                 rsp_last_result
);
   import msd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DRAIN = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam int STEP_BITS = $clog2(SUM_BITS);

   logic [2:0]            state_ff;
   logic [CFG_BITS-1:0]   frames_ff, pos_ff, lag_idx_ff;
   logic [1:0]            drain_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [SUM_BITS-1:0]   quo_ff;
   logic [COUNT_BITS-1:0] rem_ff, den_ff;

   logic [CFG_BITS-1:0]   nf, p, p_next;
   logic                  first, req_fire, rsp_fire, last_lag;
   logic [COUNT_BITS:0]   rem_sh;
   logic                  ge;
   mds_ctl_type           ctl;

   logic signed [COORD_BITS-1:0] lx[MAX_FRAMES], ly[MAX_FRAMES], lz[MAX_FRAMES];
   logic signed [COORD_BITS-1:0] ox[MAX_FRAMES], oy[MAX_FRAMES], oz[MAX_FRAMES];
   logic                         lv[MAX_FRAMES], ov[MAX_FRAMES];
   logic [SUM_BITS-1:0]          si[MAX_FRAMES], so[MAX_FRAMES];
   logic [COUNT_BITS-1:0]        ci[MAX_FRAMES], co[MAX_FRAMES];

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_fire  = rsp_valid & rsp_ready;

   always_comb begin
      if (frames_ff == '0) nf = CFG_BITS'(1);
      else if (frames_ff > CFG_BITS'(MAX_FRAMES)) nf = CFG_BITS'(MAX_FRAMES);
      else nf = frames_ff;
      p        = (pos_ff >= nf) ? '0 : pos_ff;
      first    = (p == '0);
      p_next   = p + 1'b1;
      last_lag = (lag_idx_ff + 1'b1 == nf);
      rem_sh   = {rem_ff, quo_ff[SUM_BITS-1]};
      ge       = (rem_sh >= {1'b0, den_ff});
      ctl.accept  = req_fire;
      ctl.present = req_present;
      ctl.unload  = (state_ff == ST_LOAD);
      ctl.clear   = rsp_fire & last_lag;
   end

   genvar k;
   generate
      for (k = 0; k < MAX_FRAMES; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign lx[k] = req_pos_x;
            assign ly[k] = req_pos_y;
            assign lz[k] = req_pos_z;
            assign lv[k] = req_present;
         end else begin : g_link
            assign lx[k] = ox[k-1];
            assign ly[k] = oy[k-1];
            assign lz[k] = oz[k-1];
            // a new particle sees none of the earlier frames
            assign lv[k] = ov[k-1] & ~first;
         end
         if (k == MAX_FRAMES - 1) begin : g_tail
            assign si[k] = '0;
            assign ci[k] = '0;
         end else begin : g_next
            assign si[k] = so[k+1];
            assign ci[k] = co[k+1];
         end
         msd_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .new_x(req_pos_x), .new_y(req_pos_y), .new_z(req_pos_z),
            .tap_x_in(lx[k]), .tap_y_in(ly[k]), .tap_z_in(lz[k]), .tap_valid_in(lv[k]),
            .tap_x_out(ox[k]), .tap_y_out(oy[k]), .tap_z_out(oz[k]),
            .tap_valid_out(ov[k]),
            .sum_in(si[k]), .count_in(ci[k]), .sum_out(so[k]), .count_out(co[k])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         quo_ff <= so[0];
         den_ff <= co[0];
         rem_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         quo_ff <= {quo_ff[SUM_BITS-2:0], ge};
         rem_ff <= ge ? COUNT_BITS'(rem_sh - {1'b0, den_ff}) : rem_sh[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         frames_ff  <= CFG_BITS'(64);
         pos_ff     <= '0;
         lag_idx_ff <= '0;
         drain_ff   <= '0;
         step_ff    <= '0;
      end else begin
         if (csr_valid) frames_ff <= csr_frames_in_use;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (p_next >= nf) begin
                     pos_ff <= '0;
                     if (req_final_particle) begin
                        state_ff   <= ST_DRAIN;
                        drain_ff   <= '0;
                        lag_idx_ff <= '0;
                     end
                  end else begin
                     pos_ff <= p_next;
                  end
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == 2'd2) state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_BITS'(SUM_BITS - 1)) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_fire) begin
                  lag_idx_ff <= lag_idx_ff + 1'b1;
                  state_ff   <= last_lag ? ST_IDLE : ST_LOAD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_lag         = lag_idx_ff[LAG_BITS-1:0];
   assign rsp_no_pairs    = (den_ff == '0);
   assign rsp_pair_count  = den_ff;
   assign rsp_last_result = last_lag;
   assign rsp_msd_value   = rsp_no_pairs ? '0 :
                            (quo_ff[SUM_BITS-1] ? '1 : quo_ff[MSD_BITS-1:0]);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input taken during result run");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> req_ready)
      else $error("no return to idle after last result");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_pairs) |-> (rsp_msd_value == '0 && rsp_pair_count == '0))
      else $error("empty lag with nonzero value");
   a_lag_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_result) |=> !rsp_valid)
      else $error("result shown without a division");

endmodule

// ===== verif/msd_checker.sv =====
`timescale 1ns / 1ps

module msd_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [msd_pkg::CFG_BITS-1:0]         csr_frames_in_use,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_present,
   input  logic signed [23:0]                   req_pos_x,
   input  logic signed [23:0]                   req_pos_y,
   input  logic signed [23:0]                   req_pos_z,
   input  logic                                 req_final_particle,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [msd_pkg::LAG_BITS-1:0]         rsp_lag,
   input  logic [msd_pkg::MSD_BITS-1:0]         rsp_msd_value,
   input  logic [msd_pkg::COUNT_BITS-1:0]       rsp_pair_count,
   input  logic                                 rsp_no_pairs,
   input  logic                                 rsp_last_result,
   output int                                   fail_count,
   output int                                   pending_lags
);
   import msd_pkg::*;

   typedef struct packed {
      logic [LAG_BITS-1:0]   lag;
      logic [MSD_BITS-1:0]   msd;
      logic [COUNT_BITS-1:0] count;
      logic                  empty;
      logic                  last;
   } lag_result_type;

   lag_result_type lag_queue[$];

   logic [CFG_BITS-1:0]   frames_reg;
   logic signed [23:0]    px[64], py[64], pz[64];
   logic                  pres[64];
   logic [SUM_BITS-1:0]   lag_sum[64];
   logic [COUNT_BITS-1:0] lag_count[64];
   int                    frame_pos;

   function automatic logic [63:0] sq_delta(logic signed [23:0] a, logic signed [23:0] b);
      logic signed [63:0] d;
      d = 64'(a) - 64'(b);
      return d * d;
   endfunction

   task automatic clear_particle();
      for (int i = 0; i < 64; i++) pres[i] = 1'b0;
      frame_pos = 0;
   endtask

   task automatic take_frame();
      int nf;
      int p;
      logic [63:0] d2;
      logic [64:0] s;
      lag_result_type r;
      logic [63:0] q;
      nf = (frames_reg < 1) ? 1 : (frames_reg > 64) ? 64 : int'(frames_reg);
      if (frame_pos >= nf) clear_particle();
      p = frame_pos;
      px[p] = req_pos_x; py[p] = req_pos_y; pz[p] = req_pos_z;
      pres[p] = req_present;
      if (req_present) begin
         for (int i = 0; i <= p; i++) begin
            if (pres[i]) begin
               d2 = sq_delta(px[p], px[i]) + sq_delta(py[p], py[i])
                  + sq_delta(pz[p], pz[i]);
               s = {1'b0, lag_sum[p-i]} + d2;
               lag_sum[p-i] = s[64] ? '1 : s[63:0];
               if (lag_count[p-i] != '1) lag_count[p-i]++;
            end
         end
      end
      frame_pos = p + 1;
      if (frame_pos >= nf) begin
         clear_particle();
         if (req_final_particle) begin
            for (int k = 0; k < nf; k++) begin
               r.lag = k[LAG_BITS-1:0];
               r.empty = (lag_count[k] == 0);
               r.count = lag_count[k];
               q = r.empty ? 64'd0 : lag_sum[k] / 64'(lag_count[k]);
               r.msd = q[63] ? '1 : q[62:0];
               r.last = (k + 1 == nf);
               lag_queue.push_back(r);
            end
            for (int k = 0; k < 64; k++) begin
               lag_sum[k] = '0;
               lag_count[k] = '0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      lag_result_type exp_r;
      if (reset) begin
         frames_reg = 7'd64;
         for (int k = 0; k < 64; k++) begin
            lag_sum[k] = '0;
            lag_count[k] = '0;
         end
         clear_particle();
         lag_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) frames_reg = csr_frames_in_use;
         if (req_valid && req_ready) take_frame();
         if (rsp_valid && rsp_ready) begin
            if (lag_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected transaction: lag %0d msd %0d",
                     rsp_lag, rsp_msd_value);
            end else begin
               exp_r = lag_queue.pop_front();
               if (rsp_lag !== exp_r.lag || rsp_msd_value !== exp_r.msd
                   || rsp_pair_count !== exp_r.count || rsp_no_pairs !== exp_r.empty
                   || rsp_last_result !== exp_r.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"bad result: exp lag %0d msd %0d cnt %0d np %0b last %0b,",
                               " got lag %0d msd %0d cnt %0d np %0b last %0b"},
                        exp_r.lag, exp_r.msd, exp_r.count, exp_r.empty, exp_r.last,
                        rsp_lag, rsp_msd_value, rsp_pair_count, rsp_no_pairs,
                        rsp_last_result);
               end
            end
         end
      end
      pending_lags = lag_queue.size();
   end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import msd_pkg::*;

   logic clock;
   logic reset;
   logic csr_valid, csr_ready;
   logic [CFG_BITS-1:0] csr_frames_in_use;
   logic req_valid, req_ready, req_present, req_final_particle;
   logic signed [23:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_valid, rsp_ready;
   logic [LAG_BITS-1:0] rsp_lag;
   logic [MSD_BITS-1:0] rsp_msd_value;
   logic [COUNT_BITS-1:0] rsp_pair_count;
   logic rsp_no_pairs, rsp_last_result;
   int fail_count, pending_lags;
   int send_idle_pct, stall_pct;
   int unsigned cycle_count;
   int frames_now;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   mean_square_displacement_top dut (.*);
   msd_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("mean_square_displacement_top: mismatch");
            $finish;
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic write_frames(int value);
      csr_valid <= 1'b1;
      csr_frames_in_use <= value[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      frames_now = (value < 1) ? 1 : (value > 64) ? 64 : value;
   endtask

   task automatic send_frame(logic pres, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_present <= pres;
      req_pos_x <= x; req_pos_y <= y; req_pos_z <= z;
      req_final_particle <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      // let the checker see the last accepted frame first
      @(posedge clock);
      while (pending_lags != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_coord(int mode);
      case (mode)
         0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
         1: return 24'($signed($urandom_range(4000)) - 2000);
         default: return 24'($urandom);
      endcase
   endfunction

   // one data set: random particles, final flag on the last particle and random on the others
   task automatic send_set(int particles, int mode);
      for (int p = 0; p < particles; p++)
         for (int f = 0; f < frames_now; f++)
            send_frame($urandom_range(9) != 0, rand_coord(mode), rand_coord(mode),
                       rand_coord(mode), (p == particles - 1) ? 1'b1 : 1'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0; csr_frames_in_use = '0;
      req_valid = 1'b0; req_present = 1'b0; req_final_particle = 1'b0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      send_idle_pct = 0; stall_pct = 0;
      frames_now = 64;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one frame, extremes, empty lags
      write_frames(1);
      send_frame(1, 24'sh7FFFFF, 24'sh800000, 24'sh000000, 1);
      send_frame(0, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1);
      drain();
      write_frames(0);
      send_frame(1, 24'sh000001, 24'sh000002, 24'sh000003, 1);
      drain();
      // maximal displacement across all axes, absent middle frame
      write_frames(3);
      send_frame(1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1);
      send_frame(0, 24'sh000000, 24'sh000000, 24'sh000000, 1);
      send_frame(1, 24'sh800000, 24'sh800000, 24'sh800000, 0);
      send_frame(1, 24'sh800000, 24'sh000000, 24'sh7FFFFF, 0);
      send_frame(1, 24'sh000005, 24'sh000000, 24'sh000001, 0);
      send_frame(1, 24'sh7FFFFF, 24'sh800000, 24'sh000000, 1);
      drain();
      // length change mid-particle starts a new particle; pairs already taken stay in the sums
      write_frames(4);
      for (int f = 0; f < 3; f++) send_frame(1, rand_coord(1), rand_coord(1), rand_coord(1), 0);
      drain();
      write_frames(2);
      send_frame(1, 24'sh000010, 24'sh000020, 24'sh000030, 0);
      send_frame(1, 24'sh000000, 24'sh000000, 24'sh000000, 1);
      drain();
      write_frames(127);

      // random phases
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 36) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 85 : 36) : 0;
         write_frames((ph == 0) ? 64 : $urandom_range(2, 8));
         send_set((ph == 0) ? 2 : 3, 2);
         drain();
         write_frames($urandom_range(1, 6));
         send_set(3, $urandom_range(2));
         send_set(2, 1);
         drain();
      end

      if (fail_count == 0) begin
         $display("mean_square_displacement_top: match");
      end else begin
         $display("mean_square_displacement_top: mismatch");
      end
      $finish;
   end
endmodule
